// ===== src/humidity_temp_frame_decoder_defines.svh =====
// Assertion macros for the frame decoder port-level checker.
// Depends on nothing; included by files that carry concurrent assertions.

`ifndef HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HTFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/htfd_pkg.sv =====
// Package for the humidity/temperature frame decoder: word types, status codes,
// constants, CRC-8 and divide-by-65535 helpers. Depends on nothing.

package htfd_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ABSENT   = 3'd1,
        ST_BUS_ERR  = 3'd2,
        ST_TEMP_CRC = 3'd3,
        ST_HUM_CRC  = 3'd4
    } status_t;

    // Configuration register indexes
    localparam logic CFG_SENSOR_PRESENT = 1'b0;
    localparam logic CFG_FAILURE_LIMIT  = 1'b1;

    localparam logic [7:0] FAIL_LIMIT_RESET = 8'd3;
    localparam logic [7:0] FAIL_RUN_MAX     = 8'hFF;

    // Invalid codes and extreme resets
    localparam logic signed [15:0] TEMP_INVALID  = 16'sh8000;
    localparam logic signed [15:0] TEMP_LOW_INIT = 16'sh7FFF;
    localparam logic [15:0]        HUM_INVALID   = 16'hFFFF;
    localparam logic [13:0]        HUM_FULL      = 14'd10000;

    // Conversion constants
    localparam logic [30:0] TEMP_SPAN   = 31'd17500;
    localparam logic [29:0] HUM_SPAN    = 30'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] RAW_FULL    = 17'd65535;

    // CRC-8, polynomial 0x31, init 0xFF
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    typedef struct packed {
        logic       bus_ok;
        logic [7:0] temp_high_byte;
        logic [7:0] temp_low_byte;
        logic [7:0] temp_check_byte;
        logic [7:0] hum_high_byte;
        logic [7:0] hum_low_byte;
        logic [7:0] hum_check_byte;
    } frame_word_t;

    typedef struct packed {
        status_t            status;
        logic signed [15:0] temp_centi;
        logic [15:0]        hum_centi;
        logic               stale;
        logic signed [15:0] min_temp;
        logic signed [15:0] max_temp;
        logic [13:0]        min_hum;
        logic [13:0]        max_hum;
        logic [7:0]         failure_count;
    } result_word_t;

    typedef struct packed {
        logic [15:0] quo;
        logic [15:0] rem;
    } div_t;

    // One byte through the CRC register, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
        return crc8_byte(crc8_byte(CRC_INIT, hi), lo);
    endfunction

    // num = a*65536 + b = a*65535 + (a + b); a + b stays below 2*65535
    function automatic div_t div_raw_full(input logic [30:0] num);
        logic [16:0] sum;
        div_t        res;
        sum = {2'b00, num[30:16]} + {1'b0, num[15:0]};
        if (sum >= RAW_FULL)
        begin
            res.quo = {1'b0, num[30:16]} + 16'd1;
            res.rem = 16'(sum - RAW_FULL);
        end
        else
        begin
            res.quo = {1'b0, num[30:16]};
            res.rem = sum[15:0];
        end
        return res;
    endfunction

endpackage

// ===== src/htfd_if.sv =====
// Valid/ready channel interfaces for frame words and result words.
// Depends on htfd_pkg.

interface htfd_frame_if import htfd_pkg::*; ();
    logic        valid;
    logic        ready;
    frame_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface htfd_result_if import htfd_pkg::*; ();
    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/htfd_frame_check.sv =====
// Frame check: CRC-8 of both words and the status code with its precedence.
// Depends on htfd_pkg.

module htfd_frame_check import htfd_pkg::*;
(
    input  frame_word_t frame,
    input  logic        present,
    output status_t     status
);

    logic [7:0] temp_crc;
    logic [7:0] hum_crc;

    assign temp_crc = crc8_word(frame.temp_high_byte, frame.temp_low_byte);
    assign hum_crc  = crc8_word(frame.hum_high_byte, frame.hum_low_byte);

    // absent, then bus, then temperature CRC, then humidity CRC
    always_comb
    begin
        if (!present)
            status = ST_ABSENT;
        else if (!frame.bus_ok)
            status = ST_BUS_ERR;
        else if (temp_crc != frame.temp_check_byte)
            status = ST_TEMP_CRC;
        else if (hum_crc != frame.hum_check_byte)
            status = ST_HUM_CRC;
        else
            status = ST_OK;
    end

endmodule

// ===== src/htfd_convert.sv =====
// Raw-to-centi conversion: constant multiply, then exact divide by 65535.
// Depends on htfd_pkg.

module htfd_convert import htfd_pkg::*;
(
    input  logic [15:0]        temp_raw,
    input  logic [15:0]        hum_raw,
    output logic signed [15:0] temp_centi,
    output logic [13:0]        hum_centi
);

    logic [30:0]        temp_prod;
    logic [29:0]        hum_prod;
    div_t               temp_div;
    div_t               hum_div;
    logic               round_up;
    logic signed [16:0] temp_full;

    assign temp_prod = {15'd0, temp_raw} * TEMP_SPAN;
    assign hum_prod  = {14'd0, hum_raw} * HUM_SPAN;

    assign temp_div = div_raw_full(temp_prod);
    assign hum_div  = div_raw_full({1'b0, hum_prod});

    // Negative results truncate toward zero: take the ceiling when inexact
    assign round_up  = (temp_div.quo < TEMP_OFFSET) && (temp_div.rem != 16'd0);
    assign temp_full = $signed({1'b0, temp_div.quo}) - $signed({1'b0, TEMP_OFFSET})
                     + $signed({16'd0, round_up});
    assign temp_centi = temp_full[15:0];

    // Clamp humidity at full scale
    assign hum_centi = (hum_div.quo > {2'b00, HUM_FULL}) ? HUM_FULL : hum_div.quo[13:0];

endmodule

// ===== src/humidity_temp_frame_decoder.sv =====
// Top level of the humidity/temperature frame decoder: input and result
// registers, running state and config. Depends on htfd_pkg, htfd_if,
// htfd_frame_check and htfd_convert.
//
//  channel   dir   word           handshake
//  frame     in    frame_word_t   valid/ready
//  result    out   result_word_t  valid/ready
//  cfg       in    index, data    cfg_we, no ready
//
// One word per cycle while the result side is not stalled; a taken word passes
// through the input register, then CRC/convert/state update into the result register.
// Running state updates when a word moves into the result register.
// A stalled result holds one word in the input register; frame.ready drops
// only while both registers are full and result.ready is low.
// Reset clears the state to its invalid/initial values.

module humidity_temp_frame_decoder import htfd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [7:0]     cfg_data,
    htfd_frame_if.sink     frame,
    htfd_result_if.source  result
);

    logic               sensor_present_reg;
    logic [7:0]         failure_limit_reg;
    logic [7:0]         fail_run_reg;
    logic [7:0]         fail_run_next;
    logic signed [15:0] last_temp_reg;
    logic signed [15:0] last_temp_next;
    logic [15:0]        last_hum_reg;
    logic [15:0]        last_hum_next;
    logic signed [15:0] lowest_temp_reg;
    logic signed [15:0] lowest_temp_next;
    logic signed [15:0] highest_temp_reg;
    logic signed [15:0] highest_temp_next;
    logic [13:0]        lowest_hum_reg;
    logic [13:0]        lowest_hum_next;
    logic [13:0]        highest_hum_reg;
    logic [13:0]        highest_hum_next;

    logic               stage_valid_reg;
    frame_word_t        stage_word_reg;
    logic               out_valid_reg;
    result_word_t       out_word_reg;
    result_word_t       out_word_next;

    logic               advance;
    status_t            status;
    logic               good;
    logic               failing;
    logic [7:0]         fail_inc;
    logic               have_last;
    logic               use_stale;
    logic signed [15:0] conv_temp;
    logic [13:0]        conv_hum;

    // Handshake: input register moves on whenever the result register frees up
    assign advance      = stage_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready  = !stage_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

    htfd_frame_check u_check
    (
        .frame   (stage_word_reg),
        .present (sensor_present_reg),
        .status  (status)
    );

    htfd_convert u_convert
    (
        .temp_raw   ({stage_word_reg.temp_high_byte, stage_word_reg.temp_low_byte}),
        .hum_raw    ({stage_word_reg.hum_high_byte, stage_word_reg.hum_low_byte}),
        .temp_centi (conv_temp),
        .hum_centi  (conv_hum)
    );

    // Failure bookkeeping
    assign good      = (status == ST_OK);
    assign failing   = !good && (status != ST_ABSENT);
    assign fail_inc  = (fail_run_reg == FAIL_RUN_MAX) ? fail_run_reg : fail_run_reg + 8'd1;
    assign have_last = (last_temp_reg != TEMP_INVALID) && (last_hum_reg != HUM_INVALID);
    assign use_stale = failing && (fail_inc < failure_limit_reg) && have_last;

    // Next state
    always_comb
    begin
        fail_run_next     = fail_run_reg;
        last_temp_next    = last_temp_reg;
        last_hum_next     = last_hum_reg;
        lowest_temp_next  = lowest_temp_reg;
        highest_temp_next = highest_temp_reg;
        lowest_hum_next   = lowest_hum_reg;
        highest_hum_next  = highest_hum_reg;
        if (good)
        begin
            fail_run_next  = 8'd0;
            last_temp_next = conv_temp;
            last_hum_next  = {2'b00, conv_hum};
            if (conv_temp < lowest_temp_reg)
                lowest_temp_next = conv_temp;
            if (conv_temp > highest_temp_reg)
                highest_temp_next = conv_temp;
            if (conv_hum < lowest_hum_reg)
                lowest_hum_next = conv_hum;
            if (conv_hum > highest_hum_reg)
                highest_hum_next = conv_hum;
        end
        else if (failing)
        begin
            fail_run_next = fail_inc;
        end
    end

    // Result word
    always_comb
    begin
        out_word_next.status        = status;
        out_word_next.stale         = use_stale;
        out_word_next.min_temp      = lowest_temp_next;
        out_word_next.max_temp      = highest_temp_next;
        out_word_next.min_hum       = lowest_hum_next;
        out_word_next.max_hum       = highest_hum_next;
        out_word_next.failure_count = fail_run_next;
        if (good)
        begin
            out_word_next.temp_centi = conv_temp;
            out_word_next.hum_centi  = {2'b00, conv_hum};
        end
        else if (use_stale)
        begin
            out_word_next.temp_centi = last_temp_reg;
            out_word_next.hum_centi  = last_hum_reg;
        end
        else
        begin
            out_word_next.temp_centi = TEMP_INVALID;
            out_word_next.hum_centi  = HUM_INVALID;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_present_reg <= 1'b0;
            failure_limit_reg  <= FAIL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SENSOR_PRESENT: sensor_present_reg <= cfg_data[0];
                CFG_FAILURE_LIMIT:  failure_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_run_reg     <= 8'd0;
            last_temp_reg    <= TEMP_INVALID;
            last_hum_reg     <= HUM_INVALID;
            lowest_temp_reg  <= TEMP_LOW_INIT;
            highest_temp_reg <= TEMP_INVALID;
            lowest_hum_reg   <= HUM_FULL;
            highest_hum_reg  <= 14'd0;
        end
        else if (advance)
        begin
            fail_run_reg     <= fail_run_next;
            last_temp_reg    <= last_temp_next;
            last_hum_reg     <= last_hum_next;
            lowest_temp_reg  <= lowest_temp_next;
            highest_temp_reg <= highest_temp_next;
            lowest_hum_reg   <= lowest_hum_next;
            highest_hum_reg  <= highest_hum_next;
        end
    end

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (frame.ready)
                stage_valid_reg <= frame.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
            stage_word_reg <= frame.data;
        if (advance)
            out_word_reg <= out_word_next;
    end

endmodule

// ===== src/htfd_checker.sv =====
// Port-level checker for the frame decoder, bound to the top level.
// Depends on htfd_pkg, htfd_if and humidity_temp_frame_decoder_defines.svh.

`include "humidity_temp_frame_decoder_defines.svh"

module htfd_checker import htfd_pkg::*;
(
    input logic           clk,
    input logic           rst_n,
    htfd_frame_if.sink    frame,
    htfd_result_if.source result
);

    // A stalled result word holds
    `HTFD_ASSERT_NEXT(a_result_hold, clk, rst_n, result.valid && !result.ready, result.valid && $stable(result.data), "result word changed while stalled")

    // With the result register empty the input side always takes a word
    `HTFD_ASSERT_SAME(a_frame_ready, clk, rst_n, !result.valid, frame.ready, "frame not ready with empty output")

    // Good words carry fresh, in-range values and consistent extremes
    `HTFD_ASSERT_SAME(a_good_word, clk, rst_n, result.valid && (result.data.status == ST_OK), !result.data.stale && (result.data.hum_centi <= 16'd10000) && (result.data.min_temp <= result.data.max_temp) && (result.data.min_hum <= result.data.max_hum) && (result.data.failure_count == 8'd0), "bad ok word")

    // Stale values only follow a counted failure
    `HTFD_ASSERT_SAME(a_stale_word, clk, rst_n, result.valid && result.data.stale, (result.data.status != ST_OK) && (result.data.status != ST_ABSENT) && (result.data.failure_count != 8'd0), "stale word without failure")

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .frame  (frame),
    .result (result)
);

// ===== dv/htfd_result_checker.sv =====
// Checker for the frame decoder: keeps its own copy of the decoder state and
// config, predicts one result word per accepted frame word and compares them.
// Depends on htfd_pkg.

module htfd_result_checker import htfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data,
    input  logic         frame_valid,
    input  logic         frame_ready,
    input  frame_word_t  frame_data,
    input  logic         result_valid,
    input  logic         result_ready,
    input  result_word_t result_data,
    output int           fail_count,
    output int           outstanding
);

    // Shadow config
    logic               present_q;
    logic [7:0]         limit_q;

    // Shadow decoder state
    logic [7:0]         run_len;
    logic signed [15:0] last_t;
    logic [15:0]        last_h;
    logic signed [15:0] low_t;
    logic signed [15:0] high_t;
    logic [13:0]        low_h;
    logic [13:0]        high_h;

    result_word_t expected_results[$];
    int mismatches = 0;
    int pending    = 0;

    assign fail_count  = mismatches;
    assign outstanding = pending;

    // CRC-8 over a 16-bit word, fed one bit at a time, MSB first
    function automatic logic [7:0] word_crc(input logic [15:0] w);
        logic [7:0] c;
        logic       fb;
        c = 8'hFF;
        for (int i = 15; i >= 0; i--)
        begin
            fb = c[7] ^ w[i];
            c  = {c[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
        end
        return c;
    endfunction

    // Expected result for one frame word; advances the shadow state
    function automatic result_word_t decode_frame(input frame_word_t f);
        result_word_t r;
        logic [15:0]  traw;
        logic [15:0]  hraw;
        longint       tval;
        longint       hval;
        traw         = {f.temp_high_byte, f.temp_low_byte};
        hraw         = {f.hum_high_byte, f.hum_low_byte};
        r.status     = ST_OK;
        r.temp_centi = TEMP_INVALID;
        r.hum_centi  = HUM_INVALID;
        r.stale      = 1'b0;
        if (!present_q)
            r.status = ST_ABSENT;
        else if (!f.bus_ok)
            r.status = ST_BUS_ERR;
        else if (word_crc(traw) != f.temp_check_byte)
            r.status = ST_TEMP_CRC;
        else if (word_crc(hraw) != f.hum_check_byte)
            r.status = ST_HUM_CRC;

        if (r.status == ST_OK)
        begin
            // signed division truncates toward zero
            tval = (17500 * longint'(traw) - 4500 * 65535) / 65535;
            hval = (10000 * longint'(hraw)) / 65535;
            if (hval > 10000)
                hval = 10000;
            r.temp_centi = tval[15:0];
            r.hum_centi  = hval[15:0];
            run_len      = 8'd0;
            last_t       = r.temp_centi;
            last_h       = r.hum_centi;
            if (r.temp_centi < low_t)
                low_t = r.temp_centi;
            if (r.temp_centi > high_t)
                high_t = r.temp_centi;
            if (hval[13:0] < low_h)
                low_h = hval[13:0];
            if (hval[13:0] > high_h)
                high_h = hval[13:0];
        end
        else if (r.status != ST_ABSENT)
        begin
            if (run_len != 8'hFF)
                run_len = run_len + 8'd1;
            // last values only while the run is short and a good frame was seen
            if (run_len < limit_q && last_t != TEMP_INVALID && last_h != HUM_INVALID)
            begin
                r.temp_centi = last_t;
                r.hum_centi  = last_h;
                r.stale      = 1'b1;
            end
        end

        r.min_temp      = low_t;
        r.max_temp      = high_t;
        r.min_hum       = low_h;
        r.max_hum       = high_h;
        r.failure_count = run_len;
        return r;
    endfunction

    function automatic string show_result(input result_word_t r);
        return $sformatf("st=%0d t=%0d h=%0d stale=%0d min_t=%0d max_t=%0d min_h=%0d max_h=%0d fc=%0d",
                         r.status, r.temp_centi, r.hum_centi, r.stale, r.min_temp,
                         r.max_temp, r.min_hum, r.max_hum, r.failure_count);
    endfunction

    // Compare one result word with the oldest prediction
    task automatic check_result(input result_word_t got);
        result_word_t want;
        bit           bad;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: %s", show_result(got));
            return;
        end
        want = expected_results.pop_front();
        bad  = (got.status != want.status) || (got.temp_centi != want.temp_centi) ||
               (got.hum_centi != want.hum_centi) || (got.stale != want.stale) ||
               (got.min_temp != want.min_temp) || (got.max_temp != want.max_temp) ||
               (got.min_hum != want.min_hum) || (got.max_hum != want.max_hum) ||
               (got.failure_count != want.failure_count);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("result mismatch, expected: %s", show_result(want));
                $display("                 actual:   %s", show_result(got));
            end
        end
    endtask

    // Track config, check results, predict accepted frames
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_q = 1'b0;
            limit_q   = FAIL_LIMIT_RESET;
            run_len   = 8'd0;
            last_t    = TEMP_INVALID;
            last_h    = HUM_INVALID;
            low_t     = TEMP_LOW_INIT;
            high_t    = TEMP_INVALID;
            low_h     = HUM_FULL;
            high_h    = 14'd0;
            expected_results.delete();
            pending  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SENSOR_PRESENT)
                    present_q = cfg_data[0];
                else
                    limit_q = cfg_data;
            end
            // results first, so a word never matches a prediction made this cycle
            if (result_valid && result_ready)
                check_result(result_data);
            if (frame_valid && frame_ready)
                expected_results.push_back(decode_frame(frame_data));
            pending <= expected_results.size();
        end
    end

endmodule

// ===== dv/tb_humidity_temp_frame_decoder.sv =====
// Testbench top for the frame decoder: clock, reset, config writes, frame
// stimulus and result back-pressure. Depends on htfd_pkg, htfd_if, the
// decoder and htfd_result_checker.

module tb_humidity_temp_frame_decoder;
    import htfd_pkg::*;

    localparam int STUCK_LIMIT = 1000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count;
    int outstanding;

    htfd_frame_if  frame_if ();
    htfd_result_if result_if ();

    humidity_temp_frame_decoder DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame_if),
        .result    (result_if)
    );

    htfd_result_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_valid  (frame_if.valid),
        .frame_ready  (frame_if.ready),
        .frame_data   (frame_if.data),
        .result_valid (result_if.valid),
        .result_ready (result_if.ready),
        .result_data  (result_if.data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result back-pressure, redrawn every cycle
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no word moving on either channel
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("status: fail");
        $finish;
    end

    // Frame word with correct check bytes unless told to corrupt them
    function automatic frame_word_t build_frame(input logic ok, input logic [15:0] traw,
                                                input logic [15:0] hraw, input logic bad_t,
                                                input logic bad_h);
        frame_word_t f;
        f.bus_ok          = ok;
        f.temp_high_byte  = traw[15:8];
        f.temp_low_byte   = traw[7:0];
        f.hum_high_byte   = hraw[15:8];
        f.hum_low_byte    = hraw[7:0];
        f.temp_check_byte = crc8_word(traw[15:8], traw[7:0]) ^
                            (bad_t ? 8'($urandom_range(255, 1)) : 8'h00);
        f.hum_check_byte  = crc8_word(hraw[15:8], hraw[7:0]) ^
                            (bad_h ? 8'($urandom_range(255, 1)) : 8'h00);
        return f;
    endfunction

    // Raw readings weighted toward the ends and the zero-degree crossing
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'(16850 + $urandom_range(5));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic frame_word_t random_frame(input bit good);
        logic [15:0] traw;
        logic [15:0] hraw;
        traw = pick_raw();
        hraw = pick_raw();
        if (good)
            return build_frame(1'b1, traw, hraw, 1'b0, 1'b0);
        case ($urandom_range(3))
            0:       return build_frame(1'b0, traw, hraw, 1'($urandom_range(1)),
                                        1'($urandom_range(1)));
            1:       return build_frame(1'b1, traw, hraw, 1'b1, 1'($urandom_range(1)));
            2:       return build_frame(1'b1, traw, hraw, 1'b0, 1'b1);
            default: return frame_word_t'(49'({$urandom(), $urandom()}));
        endcase
    endfunction

    // Offer one frame word; returns at the falling edge after it was taken
    task automatic push_frame(input frame_word_t f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            frame_if.valid <= 1'b0;
            @(negedge clk);
        end
        frame_if.valid <= 1'b1;
        frame_if.data  <= f;
        do
            @(posedge clk);
        while (!frame_if.ready);
        @(negedge clk);
    endtask

    // Hold the sender off until every result word has come back
    task automatic drain();
        frame_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic configure(input logic present, input logic [7:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SENSOR_PRESENT;
        cfg_data  <= {7'd0, present};
        @(negedge clk);
        cfg_index <= CFG_FAILURE_LIMIT;
        cfg_data  <= limit;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_phase(input logic present, input logic [7:0] limit,
                             input int idle_pct, input int stall_pct);
        drain();
        configure(present, limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Alternating runs of good frames and failed transfers
    task automatic run_phase(input int count, input int max_fail);
        int sent;
        int glen;
        int flen;
        sent = 0;
        while (sent < count)
        begin
            glen = $urandom_range(4, 1);
            flen = $urandom_range(max_fail, 1);
            repeat (glen)
            begin
                push_frame(random_frame(1'b1));
                sent++;
            end
            repeat (flen)
            begin
                push_frame(random_frame(1'b0));
                sent++;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_SENSOR_PRESENT;
        cfg_data       = 8'd0;
        frame_if.valid = 1'b0;
        frame_if.data  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // sensor absent after reset: invalid codes, no counting
        push_frame(build_frame(1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0));
        push_frame(build_frame(1'b0, 16'h1234, 16'h5678, 1'b1, 1'b1));

        set_phase(1'b1, 8'd3, 0, 0);
        // failures before any good frame: nothing stale to report
        push_frame(build_frame(1'b1, 16'h4000, 16'h4000, 1'b1, 1'b0));
        push_frame(build_frame(1'b0, 16'h4000, 16'h4000, 1'b1, 1'b1));
        // conversion extremes and the zero-degree crossing
        push_frame(build_frame(1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0));
        push_frame(build_frame(1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
        push_frame(build_frame(1'b1, 16'd16852, 16'h0001, 1'b0, 1'b0));
        push_frame(build_frame(1'b1, 16'd16853, 16'h8000, 1'b0, 1'b0));
        // precedence: bus over temperature CRC over humidity CRC, up to the limit
        push_frame(build_frame(1'b0, 16'h1111, 16'h2222, 1'b1, 1'b1));
        push_frame(build_frame(1'b1, 16'h1111, 16'h2222, 1'b1, 1'b1));
        push_frame(build_frame(1'b1, 16'h1111, 16'h2222, 1'b0, 1'b1));
        push_frame(build_frame(1'b1, 16'h1111, 16'h2222, 1'b0, 1'b1));
        push_frame(random_frame(1'b1));

        // limit of one: stale values never reported
        set_phase(1'b1, 8'd1, 0, 0);
        push_frame(build_frame(1'b0, 16'h6000, 16'h6000, 1'b0, 1'b0));
        push_frame(random_frame(1'b1));

        // limit of zero
        set_phase(1'b1, 8'd0, 0, 0);
        push_frame(build_frame(1'b1, 16'h6000, 16'h6000, 1'b1, 1'b0));
        push_frame(random_frame(1'b1));

        // random phases
        set_phase(1'b1, 8'd3, 0, 0);
        run_phase(300, 5);

        set_phase(1'b1, 8'd1, 63, 0);
        run_phase(250, 5);

        // long failure run saturates the count at the widest limit
        set_phase(1'b1, 8'd255, 0, 63);
        push_frame(random_frame(1'b1));
        repeat (270) push_frame(random_frame(1'b0));
        run_phase(100, 6);

        set_phase(1'b0, 8'd3, 19, 19);
        run_phase(60, 4);

        set_phase(1'b1, 8'd0, 19, 19);
        run_phase(300, 4);

        set_phase(1'b1, 8'($urandom_range(254, 2)), 0, 0);
        run_phase(200, 8);

        drain();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/htfd_pkg.sv
src/htfd_if.sv
src/htfd_frame_check.sv
src/htfd_convert.sv
src/humidity_temp_frame_decoder.sv
src/htfd_checker.sv
dv/htfd_result_checker.sv
dv/tb_humidity_temp_frame_decoder.sv
